[design/jss_pkg.sv]
// ----------------------------------------------------------------------------
// JTAG scan sequencer package
// Shared types, constants and the control store of the scan sequencer.
// ----------------------------------------------------------------------------
package jss_pkg;

  localparam int MAX_SCAN_LEN = 32;
  localparam int DATA_W       = 32;
  localparam int LEN_FIELD_W  = 6;
  localparam int LEN_W        = $clog2(MAX_SCAN_LEN + 1);
  localparam int ADDR_W       = 4;

  localparam logic [1:0] CMD_RESET       = 2'd0;
  localparam logic [1:0] CMD_SHIFT_IR    = 2'd1;
  localparam logic [1:0] CMD_SHIFT_DR    = 2'd2;
  localparam logic [1:0] CMD_SHIFT_DR_CAP = 2'd3;

  typedef struct packed {
    logic [1:0]             command;
    logic [LEN_FIELD_W-1:0] length;
    logic [DATA_W-1:0]      tdi_bits;
    logic [DATA_W-1:0]      tdo_bits;
  } jss_in_t;

  typedef struct packed {
    logic              tms;
    logic              tdi;
    logic              sample_tdo;
    logic [DATA_W-1:0] tdo_captured;
    logic              last;
  } jss_out_t;

  // Control store addresses. The IR lead-in falls through into the DR lead-in.
  typedef enum logic [ADDR_W-1:0] {
    ADDR_RST0  = 4'd0,
    ADDR_RST1  = 4'd1,
    ADDR_RST2  = 4'd2,
    ADDR_RST3  = 4'd3,
    ADDR_RST4  = 4'd4,
    ADDR_RST5  = 4'd5,
    ADDR_IR0   = 4'd6,
    ADDR_DR0   = 4'd7,
    ADDR_PRE1  = 4'd8,
    ADDR_PRE2  = 4'd9,
    ADDR_SHIFT = 4'd10,
    ADDR_UPD   = 4'd11,
    ADDR_IDLE  = 4'd12
  } jss_addr_e;

  typedef enum logic [1:0] {
    TMS_ZERO,
    TMS_ONE,
    TMS_FINAL
  } jss_tms_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_DONE
  } jss_jmp_e;

  typedef struct packed {
    jss_tms_e tms_sel;
    logic     shift;
    logic     cap_en;
    logic     last;
    jss_jmp_e jmp;
  } jss_uword_t;

  typedef struct packed {
    logic load;
    logic shift;
  } jss_dp_ctl_t;

  typedef struct packed {
    logic              final_bit;
    logic              tdi_bit;
    logic [DATA_W-1:0] cap;
  } jss_dp_sts_t;

  function automatic jss_uword_t jss_ucode(input jss_addr_e addr);
    jss_uword_t w;
    w = '{tms_sel: TMS_ZERO, shift: 1'b0, cap_en: 1'b0, last: 1'b0, jmp: JMP_DONE};
    unique case (addr)
      ADDR_RST0, ADDR_RST1, ADDR_RST2, ADDR_RST3, ADDR_RST4: begin
        w.tms_sel = TMS_ONE;
        w.jmp     = JMP_NEXT;
      end
      ADDR_RST5: begin
        w.last = 1'b1;
      end
      ADDR_IR0, ADDR_DR0, ADDR_UPD: begin
        w.tms_sel = TMS_ONE;
        w.jmp     = JMP_NEXT;
      end
      ADDR_PRE1, ADDR_PRE2: begin
        w.jmp = JMP_NEXT;
      end
      ADDR_SHIFT: begin
        w.tms_sel = TMS_FINAL;
        w.shift   = 1'b1;
        w.jmp     = JMP_LOOP;
      end
      ADDR_IDLE: begin
        w.cap_en = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.jmp = JMP_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

[design/jss_datapath.sv]
// ----------------------------------------------------------------------------
// JTAG scan sequencer datapath
// TDI shift register, remaining bit counter and captured TDO word.
// ----------------------------------------------------------------------------
module jss_datapath import jss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  jss_in_t     in_data_i,
  input  jss_dp_ctl_t ctl_i,
  output jss_dp_sts_t sts_o
);

  logic [DATA_W-1:0] tdi_q, tdi_d;
  logic [DATA_W-1:0] cap_q, cap_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_sat;
  logic [DATA_W-1:0] mask;

  always_comb begin
    if (in_data_i.length > LEN_FIELD_W'(MAX_SCAN_LEN)) begin
      len_sat = LEN_W'(MAX_SCAN_LEN);
    end else begin
      len_sat = LEN_W'(in_data_i.length);
    end
    for (int i = 0; i < DATA_W; i++) begin
      mask[i] = (32'(i) < 32'(len_sat));
    end
  end

  always_comb begin
    tdi_d = tdi_q;
    cap_d = cap_q;
    cnt_d = cnt_q;
    if (ctl_i.load) begin
      tdi_d = in_data_i.tdi_bits;
      cnt_d = len_sat;
      if (in_data_i.command == CMD_SHIFT_DR_CAP) begin
        cap_d = in_data_i.tdo_bits & mask;
      end else begin
        cap_d = '0;
      end
    end else if (ctl_i.shift) begin
      // Bits past the top of the word shift out as zero.
      tdi_d = tdi_q >> 1;
      cnt_d = cnt_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tdi_q <= '0;
      cap_q <= '0;
      cnt_q <= '0;
    end else begin
      tdi_q <= tdi_d;
      cap_q <= cap_d;
      cnt_q <= cnt_d;
    end
  end

  assign sts_o.final_bit = (cnt_q == LEN_W'(1));
  assign sts_o.tdi_bit   = tdi_q[0];
  assign sts_o.cap       = cap_q;

endmodule

[design/jss_sequencer.sv]
// ----------------------------------------------------------------------------
// JTAG scan sequencer control
// Step counter over the control store, command dispatch and jump logic.
// ----------------------------------------------------------------------------
module jss_sequencer import jss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  jss_in_t     in_data_i,
  input  logic        slot_free_i,
  input  logic        final_bit_i,
  output logic        busy_o,
  output logic        step_o,
  output jss_uword_t  uword_o,
  output jss_dp_ctl_t dp_ctl_o
);

  logic       busy_q, busy_d;
  jss_addr_e  pc_q, pc_d;
  jss_uword_t uw;
  logic       accept;
  logic       step;

  assign uw     = jss_ucode(pc_q);
  assign accept = in_valid_i && !busy_q;
  assign step   = busy_q && slot_free_i;

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (accept) begin
      if (in_data_i.command == CMD_RESET) begin
        busy_d = 1'b1;
        pc_d   = ADDR_RST0;
      end else if (in_data_i.length != '0) begin
        // A zero-length scan is taken and dropped without any transfer.
        busy_d = 1'b1;
        pc_d   = (in_data_i.command == CMD_SHIFT_IR) ? ADDR_IR0 : ADDR_DR0;
      end
    end else if (step) begin
      unique case (uw.jmp)
        JMP_NEXT: pc_d = jss_addr_e'(ADDR_W'(pc_q) + ADDR_W'(1));
        JMP_LOOP: begin
          if (final_bit_i) begin
            pc_d = jss_addr_e'(ADDR_W'(pc_q) + ADDR_W'(1));
          end
        end
        JMP_DONE: busy_d = 1'b0;
        default:  busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= ADDR_RST0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign busy_o         = busy_q;
  assign step_o         = step;
  assign uword_o        = uw;
  assign dp_ctl_o.load  = accept;
  assign dp_ctl_o.shift = step && uw.shift;

  a_shift_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && pc_q == ADDR_SHIFT && !final_bit_i |=> pc_q == ADDR_SHIFT && busy_q)
    else $error("shift step left the shift loop early");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && uw.last |=> !busy_q)
    else $error("sequencer still busy after the final step");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !dp_ctl_o.load)
    else $error("datapath loaded while a command is running");

endmodule

[design/jtag_scan_sequencer_core.sv]
// ----------------------------------------------------------------------------
// JTAG scan sequencer core
// Turns reset/scan commands into one TMS/TDI transfer per unstalled TCK cycle.
// ----------------------------------------------------------------------------
// A command is taken only while no other command is running, and its results
// then leave at one transfer per clock through the output register, pausing
// whenever the output is stalled. A reset command gives 6 transfers, a DR scan
// length+5 and an IR scan length+6 (38 at most, for a 32-bit IR scan); the
// length is clamped to MAX_SCAN_LEN. A scan of length zero is taken and gives
// nothing. The pace is set by the microprogram step counter, which steps once
// per transfer and holds on the shift word until its final bit; a new command
// is taken in the cycle after the final transfer enters the output register.
module jtag_scan_sequencer_core import jss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  jss_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output jss_out_t out_data_o
);

  logic        busy;
  logic        step;
  logic        slot_free;
  jss_uword_t  uw;
  jss_dp_ctl_t dp_ctl;
  jss_dp_sts_t dp_sts;

  logic     out_valid_q, out_valid_d;
  jss_out_t out_q, out_d;

  assign slot_free = !out_valid_q || !out_stall_i;

  jss_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .slot_free_i (slot_free),
    .final_bit_i (dp_sts.final_bit),
    .busy_o      (busy),
    .step_o      (step),
    .uword_o     (uw),
    .dp_ctl_o    (dp_ctl)
  );

  jss_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .ctl_i     (dp_ctl),
    .sts_o     (dp_sts)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step) begin
      out_valid_d = 1'b1;
      unique case (uw.tms_sel)
        TMS_ZERO:  out_d.tms = 1'b0;
        TMS_ONE:   out_d.tms = 1'b1;
        TMS_FINAL: out_d.tms = dp_sts.final_bit;
        default:   out_d.tms = 1'b0;
      endcase
      out_d.tdi          = uw.shift && dp_sts.tdi_bit;
      out_d.sample_tdo   = uw.shift;
      out_d.tdo_captured = uw.cap_en ? dp_sts.cap : '0;
      out_d.last         = uw.last;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cap_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tdo_captured != '0 |-> out_data_o.last)
    else $error("captured word shown before the final transfer");

  a_sample_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sample_tdo |-> !out_data_o.last)
    else $error("scan bit marked as the final transfer");

endmodule
